[rtl/srtf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Field widths, record kinds and the command/status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int WORD_W   = ARR_W + 2 * BURST_W;
  localparam int TICK_W   = 21;
  localparam int TOTAL_W  = 25;
  localparam int Q8_W     = 29;
  localparam int IDX_W    = 4;
  localparam int DIVQ_W   = TOTAL_W + 8;
  localparam int DIV_STEPS = DIVQ_W;
  localparam int DIVC_W   = $clog2(DIV_STEPS + 1);

  localparam logic KIND_COMPLETION = 1'b0;
  localparam logic KIND_SUMMARY    = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_read;
    logic serve;
    logic idle_advance;
    logic finish;
    logic emit_completion;
    logic div_start;
    logic div_step;
    logic emit_summary;
  } srtf_cmd_t;

  typedef struct packed {
    logic found;
    logic any_left;
    logic next_ahead;
    logic best_last;
    logic scan_last;
    logic run_done;
    logic div_last;
    logic out_free;
  } srtf_sts_t;

endpackage
`default_nettype wire

[rtl/srtf_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF scheduler
// Shortest-remaining-time-first scheduler: loads processes, runs them tick by
// tick and reports each completion and the run averages.
// ----------------------------------------------------------------------------
// Loading takes one process per cycle. The item marked last_process starts the
// run and the input stalls until the summary record has been placed in the
// output register.
// Each scheduling tick scans every loaded process through the single read port
// of the process store, one slot per cycle, then waits for the last read and
// decides; a completion adds a finish and an emit state, the latter held by
// any output stall, and idle gaps are skipped in one tick. The closing averages
// come from a bit-serial divider that runs a load step and 33 quotient steps
// before the summary record is issued.
// ----------------------------------------------------------------------------
module srtf_scheduler import srtf_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [ARR_W-1:0]   arrival_tick,
  input  wire logic [BURST_W-1:0] burst_length,
  input  wire logic               last_process,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic                    result_kind,
  output logic [IDX_W-1:0]        process_index,
  output logic [TICK_W-1:0]       waiting_ticks,
  output logic [TICK_W-1:0]       turnaround_ticks,
  output logic [Q8_W-1:0]         avg_waiting_q8,
  output logic [Q8_W-1:0]         avg_turnaround_q8,
  output logic                    last_result
);

  srtf_cmd_t cmd;
  srtf_sts_t sts;

  srtf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .last_process (last_process),
    .sts          (sts),
    .cmd          (cmd)
  );

  srtf_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .arrival_tick      (arrival_tick),
    .burst_length      (burst_length),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result_kind       (result_kind),
    .process_index     (process_index),
    .waiting_ticks     (waiting_ticks),
    .turnaround_ticks  (turnaround_ticks),
    .avg_waiting_q8    (avg_waiting_q8),
    .avg_turnaround_q8 (avg_turnaround_q8),
    .last_result       (last_result)
  );

endmodule
`default_nettype wire

[rtl/srtf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF controller
// Sequences loading, the per-tick scan/serve loop, completion and summary
// transfers, and the averaging division.
// ----------------------------------------------------------------------------
module srtf_ctrl import srtf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic      item_stall,
  input  wire logic last_process,
  input  wire srtf_sts_t sts,
  output srtf_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_FINISH,
    ST_EMIT,
    ST_DIV_START,
    ST_DIV,
    ST_SUMMARY
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && !item_stall) begin
          cmd.load = 1'b1;
          if (last_process) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.run_done) begin
          state_next = ST_DIV_START;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_read = 1'b1;
        if (sts.scan_last) state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.found) begin
          cmd.serve  = 1'b1;
          state_next = sts.best_last ? ST_FINISH : ST_CHECK;
        end else if (sts.any_left) begin
          cmd.idle_advance = 1'b1;
          state_next       = ST_CHECK;
        end else begin
          state_next = ST_DIV_START;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_completion = 1'b1;
          state_next          = ST_CHECK;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_SUMMARY;
      end
      ST_SUMMARY: begin
        if (sts.out_free) begin
          cmd.emit_summary = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_stall <= 1'b0;
    end else begin
      state      <= state_next;
      item_stall <= (state_next != ST_IDLE);
    end
  end

endmodule
`default_nettype wire

[rtl/srtf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF datapath
// Process store, scan comparator, tick and total counters, two-lane
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module srtf_datapath import srtf_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire srtf_cmd_t            cmd,
  output srtf_sts_t                 sts,
  input  wire logic [ARR_W-1:0]     arrival_tick,
  input  wire logic [BURST_W-1:0]   burst_length,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic                      result_kind,
  output logic [IDX_W-1:0]          process_index,
  output logic [TICK_W-1:0]         waiting_ticks,
  output logic [TICK_W-1:0]         turnaround_ticks,
  output logic [Q8_W-1:0]           avg_waiting_q8,
  output logic [Q8_W-1:0]           avg_turnaround_q8,
  output logic                      last_result
);

  localparam int LW = $clog2(MAX_PROCS + 1);
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW = LW + 1;

  logic [WORD_W-1:0]  mem [MAX_PROCS];
  logic [WORD_W-1:0]  rd_word;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      scan_addr;

  logic [LW-1:0]      loaded_count;
  logic [LW-1:0]      finished_count;
  logic [TICK_W-1:0]  current_tick;
  logic [TOTAL_W-1:0] total_waiting;
  logic [TOTAL_W-1:0] total_turnaround;

  logic               found;
  logic               any_left;
  logic [IW-1:0]      best_idx;
  logic [ARR_W-1:0]   best_arr;
  logic [BURST_W-1:0] best_burst;
  logic [BURST_W-1:0] best_rem;
  logic [ARR_W-1:0]   next_arr;
  logic [TICK_W-1:0]  turn;
  logic [TICK_W-1:0]  wait_t;

  logic [DIVQ_W-1:0]  quot_w, quot_t;
  logic [RW-1:0]      rem_w, rem_t;
  logic [LW-1:0]      divisor;
  logic [DIVC_W-1:0]  div_cnt;

  logic [BURST_W-1:0] burst_fix;
  logic               full;
  logic [ARR_W-1:0]   rd_arr;
  logic [BURST_W-1:0] rd_rem;
  logic               take;
  logic               pend;
  logic [RW-1:0]      sh_w, sh_t;
  logic               ge_w, ge_t;

  assign burst_fix = (burst_length == '0) ? BURST_W'(1) : burst_length;
  assign full      = (loaded_count == LW'(MAX_PROCS));
  assign rd_arr    = rd_word[WORD_W-1 -: ARR_W];
  assign rd_rem    = rd_word[BURST_W-1:0];

  assign take = rd_vld && (rd_rem != '0) && (TICK_W'(rd_arr) <= current_tick)
                && (!found || (rd_rem < best_rem));
  assign pend = rd_vld && (rd_rem != '0) && (!any_left || (rd_arr < next_arr));

  assign sh_w = {rem_w[RW-2:0], quot_w[DIVQ_W-1]};
  assign sh_t = {rem_t[RW-2:0], quot_t[DIVQ_W-1]};
  assign ge_w = (sh_w >= RW'(divisor));
  assign ge_t = (sh_t >= RW'(divisor));

  always_comb begin
    sts.found      = found;
    sts.any_left   = any_left;
    sts.next_ahead = (TICK_W'(next_arr) > current_tick);
    sts.best_last  = (best_rem == BURST_W'(1));
    sts.scan_last  = (LW'(scan_addr) == (loaded_count - LW'(1)));
    sts.run_done   = (finished_count == loaded_count);
    sts.div_last   = (div_cnt == DIVC_W'(1));
    sts.out_free   = !result_valid || !result_stall;
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[loaded_count[IW-1:0]] <= {arrival_tick, burst_fix, burst_fix};
    end else if (cmd.serve) begin
      mem[best_idx] <= {best_arr, best_burst, best_rem - BURST_W'(1)};
    end
    if (cmd.scan_read) begin
      rd_word <= mem[scan_addr];
    end
  end

  // scan comparator and best-candidate registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    if (take) begin
      best_idx   <= rd_idx;
      best_arr   <= rd_arr;
      best_burst <= rd_word[2*BURST_W-1 -: BURST_W];
      best_rem   <= rd_rem;
    end
    if (pend) begin
      next_arr <= rd_arr;
    end
    if (cmd.serve) begin
      turn <= current_tick - TICK_W'(best_arr) + TICK_W'(1);
    end
    if (cmd.finish) begin
      wait_t <= turn - TICK_W'(best_burst);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      any_left  <= 1'b0;
      scan_addr <= '0;
    end else begin
      rd_vld <= cmd.scan_read;
      if (cmd.scan_start) begin
        found     <= 1'b0;
        any_left  <= 1'b0;
        scan_addr <= '0;
      end else begin
        if (cmd.scan_read) scan_addr <= scan_addr + IW'(1);
        if (take) found <= 1'b1;
        if (pend) any_left <= 1'b1;
      end
    end
  end

  // run counters
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_summary) begin
      loaded_count     <= '0;
      finished_count   <= '0;
      current_tick     <= '0;
      total_waiting    <= '0;
      total_turnaround <= '0;
    end else begin
      if (cmd.load && !full) loaded_count <= loaded_count + LW'(1);
      if (cmd.serve) begin
        current_tick <= current_tick + TICK_W'(1);
      end else if (cmd.idle_advance) begin
        current_tick <= sts.next_ahead ? TICK_W'(next_arr) : current_tick + TICK_W'(1);
      end
      if (cmd.finish) begin
        finished_count   <= finished_count + LW'(1);
        total_turnaround <= total_turnaround + TOTAL_W'(turn);
      end
      if (cmd.emit_completion) begin
        total_waiting <= total_waiting + TOTAL_W'(wait_t);
      end
    end
  end

  // two-lane restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DIVC_W'(DIV_STEPS);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DIVC_W'(1);
    end
    if (cmd.div_start) begin
      quot_w  <= {total_waiting, 8'd0};
      quot_t  <= {total_turnaround, 8'd0};
      rem_w   <= '0;
      rem_t   <= '0;
      divisor <= (loaded_count == '0) ? LW'(1) : loaded_count;
    end else if (cmd.div_step) begin
      quot_w <= {quot_w[DIVQ_W-2:0], ge_w};
      quot_t <= {quot_t[DIVQ_W-2:0], ge_t};
      rem_w  <= ge_w ? sh_w - RW'(divisor) : sh_w;
      rem_t  <= ge_t ? sh_t - RW'(divisor) : sh_t;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_completion || cmd.emit_summary) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.emit_completion) begin
      result_kind       <= KIND_COMPLETION;
      process_index     <= IDX_W'(best_idx);
      waiting_ticks     <= wait_t;
      turnaround_ticks  <= turn;
      avg_waiting_q8    <= '0;
      avg_turnaround_q8 <= '0;
      last_result       <= 1'b0;
    end else if (cmd.emit_summary) begin
      result_kind       <= KIND_SUMMARY;
      process_index     <= '0;
      waiting_ticks     <= '0;
      turnaround_ticks  <= '0;
      avg_waiting_q8    <= quot_w[Q8_W-1:0];
      avg_turnaround_q8 <= quot_t[Q8_W-1:0];
      last_result       <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/srtf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRTF checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module srtf_checker import srtf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_stall,
  input wire logic               last_process,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic               result_kind,
  input wire logic [IDX_W-1:0]   process_index,
  input wire logic [TICK_W-1:0]  waiting_ticks,
  input wire logic [TICK_W-1:0]  turnaround_ticks,
  input wire logic [Q8_W-1:0]    avg_waiting_q8,
  input wire logic [Q8_W-1:0]    avg_turnaround_q8,
  input wire logic               last_result
);

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_kind)
      && $stable(process_index) && $stable(waiting_ticks)
      && $stable(turnaround_ticks) && $stable(avg_waiting_q8)
      && $stable(avg_turnaround_q8) && $stable(last_result))
    else $error("stalled result changed");

  a_completion_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_COMPLETION) |->
      (avg_waiting_q8 == '0) && (avg_turnaround_q8 == '0) && !last_result)
    else $error("completion record carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_SUMMARY) |->
      last_result && (process_index == '0) && (waiting_ticks == '0)
      && (turnaround_ticks == '0))
    else $error("summary record malformed");

  // start of run closes the input
  a_run_stalls_input: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && last_process |=> item_stall)
    else $error("input open after last process");

  // nothing follows the summary until a new run
  a_summary_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && last_result |=> !result_valid)
    else $error("result after summary transfer");

endmodule

bind srtf_scheduler srtf_checker u_srtf_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item_valid),
  .item_stall        (item_stall),
  .last_process      (last_process),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .result_kind       (result_kind),
  .process_index     (process_index),
  .waiting_ticks     (waiting_ticks),
  .turnaround_ticks  (turnaround_ticks),
  .avg_waiting_q8    (avg_waiting_q8),
  .avg_turnaround_q8 (avg_turnaround_q8),
  .last_result       (last_result)
);
`default_nettype wire
